@@ src/lpsl_pkg.sv @@
// lpsl_pkg: shared constants and types for the LED PWM driver serial loader
// used by lpsl_store and led_pwm_driver_serial_loader; no dependencies
package lpsl_pkg;

  localparam int NUM_DRIVERS_DEF = 1;
  localparam int CH_PER_DRV      = 16;

  localparam int GRAY_W   = 12;
  localparam int DOT_W    = 6;
  localparam int BIT_W    = $clog2(GRAY_W);
  localparam int MODE_W   = 3;
  localparam int CHAN_W   = 8;
  localparam int VALUE_W  = 16;

  localparam logic [GRAY_W-1:0] GRAY_MAX = '1;
  localparam logic [DOT_W-1:0]  DOT_MAX  = '1;

  localparam logic [MODE_W-1:0] MODE_SET_GRAY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_DOT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PROG_DOT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REFRESH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd4;

  typedef struct packed {
    logic gray_we;
    logic dot_we;
  } store_wr_t;

endpackage

@@ src/lpsl_store.sv @@
// lpsl_store: per-channel grayscale and dot-correction memories
// entries never written read as reset values through per-entry valid bits
// depends on lpsl_pkg
module lpsl_store #(
  parameter int CH = lpsl_pkg::CH_PER_DRV * lpsl_pkg::NUM_DRIVERS_DEF,
  parameter int AW = $clog2(CH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpsl_pkg::store_wr_t         wr,
  input  logic [AW-1:0]               waddr,
  input  logic [lpsl_pkg::GRAY_W-1:0] wgray,
  input  logic [lpsl_pkg::DOT_W-1:0]  wdot,
  input  logic [AW-1:0]               raddr,
  output logic [lpsl_pkg::GRAY_W-1:0] rd_gray,
  output logic [lpsl_pkg::DOT_W-1:0]  rd_dot
);

  logic [lpsl_pkg::GRAY_W-1:0] gray_mem [CH];
  logic [lpsl_pkg::DOT_W-1:0]  dot_mem  [CH];
  logic [CH-1:0]               gray_vld_r;
  logic [CH-1:0]               dot_vld_r;
  logic [lpsl_pkg::GRAY_W-1:0] gray_q_r;
  logic [lpsl_pkg::DOT_W-1:0]  dot_q_r;
  logic                        gray_qv_r;
  logic                        dot_qv_r;

  always_ff @(posedge clk) begin
    if (wr.gray_we) begin
      gray_mem[waddr] <= wgray;
    end
    if (wr.dot_we) begin
      dot_mem[waddr] <= wdot;
    end
    gray_q_r <= gray_mem[raddr];
    dot_q_r  <= dot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_vld_r <= '0;
      dot_vld_r  <= '0;
      gray_qv_r  <= 1'b0;
      dot_qv_r   <= 1'b0;
    end else begin
      if (wr.gray_we) begin
        gray_vld_r[waddr] <= 1'b1;
      end
      if (wr.dot_we) begin
        dot_vld_r[waddr] <= 1'b1;
      end
      gray_qv_r <= gray_vld_r[raddr];
      dot_qv_r  <= dot_vld_r[raddr];
    end
  end

  assign rd_gray = gray_qv_r ? gray_q_r : '0;
  assign rd_dot  = dot_qv_r ? dot_q_r : lpsl_pkg::DOT_MAX;

endmodule

@@ src/led_pwm_driver_serial_loader.sv @@
// led_pwm_driver_serial_loader: command interface and bit-serial shifter for a
// cascade of 16-channel LED PWM drivers; depends on lpsl_pkg and lpsl_store
// result: registered, valid in the cycle after the input transaction
// throughput: one command per cycle while out_ready allows; a shift start stalls input
// shift: one serial bit per tick from a 12-bit shift register, next word prefetched
// reset: stores read as 0 / 63 via per-entry valid bits, no clearing pass
module led_pwm_driver_serial_loader #(
  parameter int NUM_DRIVERS = lpsl_pkg::NUM_DRIVERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lpsl_pkg::MODE_W-1:0]  in_mode,
  input  logic [lpsl_pkg::CHAN_W-1:0]  in_channel,
  input  logic [lpsl_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_serial_data,
  output logic                         out_clock_pulse,
  output logic                         out_latch_pulse,
  output logic                         out_blank_pulse,
  output logic                         out_program_select,
  output logic                         out_busy_res,
  output logic                         out_accepted
);

  localparam int CH   = lpsl_pkg::CH_PER_DRV * NUM_DRIVERS;
  localparam int AW   = $clog2(CH);
  localparam int GW   = lpsl_pkg::GRAY_W;
  localparam int DW   = lpsl_pkg::DOT_W;
  localparam int BW   = lpsl_pkg::BIT_W;
  localparam logic [AW-1:0] CH_TOP = AW'(CH - 1);
  localparam logic [BW-1:0] GRAY_TOP = BW'(GW - 1);
  localparam logic [BW-1:0] DOT_TOP  = BW'(DW - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DOT_SHIFT,
    PH_DOT_LATCH,
    PH_GRAY_SHIFT
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [AW-1:0] ch_r, ch_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic [GW-1:0] shreg_r, shreg_nxt;
  logic          load_r, load_nxt;
  logic          new_gray_r, new_gray_nxt;
  logic          latch_pend_r, latch_pend_nxt;
  logic          sel_r, sel_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_sdata_r, out_sdata_nxt;
  logic out_clk_r, out_clk_nxt;
  logic out_latch_r, out_latch_nxt;
  logic out_blank_r, out_blank_nxt;
  logic out_sel_r, out_sel_nxt;
  logic out_busy_r, out_busy_nxt;
  logic out_acc_r, out_acc_nxt;

  logic                accept;
  logic                busy;
  logic                in_range;
  logic [GW-1:0]       gray_sat;
  logic [DW-1:0]       dot_sat;
  logic [GW-1:0]       load_word;
  logic [AW-1:0]       rd_addr;
  logic [GW-1:0]       rd_gray;
  logic [DW-1:0]       rd_dot;
  lpsl_pkg::store_wr_t wr;

  assign in_ready = !load_r && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign busy     = (phase_r != PH_IDLE);
  assign in_range = ({1'b0, in_channel} < 9'(CH));
  assign gray_sat = (|in_value[lpsl_pkg::VALUE_W-1:GW]) ? lpsl_pkg::GRAY_MAX : in_value[GW-1:0];
  assign dot_sat  = (|in_value[lpsl_pkg::VALUE_W-1:DW]) ? lpsl_pkg::DOT_MAX : in_value[DW-1:0];
  assign load_word = (phase_r == PH_DOT_SHIFT) ? {rd_dot, {(GW-DW){1'b0}}} : rd_gray;
  assign rd_addr  = load_nxt ? ch_nxt : ((ch_r == '0) ? '0 : ch_r - AW'(1));

  lpsl_store #(
    .CH (CH),
    .AW (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .waddr   (in_channel[AW-1:0]),
    .wgray   (gray_sat),
    .wdot    (dot_sat),
    .raddr   (rd_addr),
    .rd_gray (rd_gray),
    .rd_dot  (rd_dot)
  );

  always_comb begin
    phase_nxt      = phase_r;
    ch_nxt         = ch_r;
    bit_nxt        = bit_r;
    shreg_nxt      = shreg_r;
    load_nxt       = 1'b0;
    new_gray_nxt   = new_gray_r;
    latch_pend_nxt = latch_pend_r;
    sel_nxt        = sel_r;
    wr             = '0;
    out_valid_nxt  = out_valid_r;
    out_sdata_nxt  = out_sdata_r;
    out_clk_nxt    = out_clk_r;
    out_latch_nxt  = out_latch_r;
    out_blank_nxt  = out_blank_r;
    out_sel_nxt    = out_sel_r;
    out_busy_nxt   = out_busy_r;
    out_acc_nxt    = out_acc_r;

    if (load_r) begin
      shreg_nxt = load_word;
    end

    if (accept) begin
      out_sdata_nxt = 1'b0;
      out_clk_nxt   = 1'b0;
      out_latch_nxt = 1'b0;
      out_blank_nxt = 1'b0;
      out_acc_nxt   = 1'b1;
      if (busy && in_mode <= lpsl_pkg::MODE_REFRESH) begin
        out_acc_nxt = 1'b0;
      end else begin
        unique case (in_mode)
          lpsl_pkg::MODE_SET_GRAY: begin
            if (in_range) begin
              wr.gray_we   = 1'b1;
              new_gray_nxt = 1'b1;
            end
          end
          lpsl_pkg::MODE_SET_DOT: begin
            if (in_range) begin
              wr.dot_we = 1'b1;
            end
          end
          lpsl_pkg::MODE_PROG_DOT: begin
            sel_nxt   = 1'b1;
            phase_nxt = PH_DOT_SHIFT;
            ch_nxt    = CH_TOP;
            bit_nxt   = DOT_TOP;
            load_nxt  = 1'b1;
          end
          lpsl_pkg::MODE_REFRESH: begin
            out_blank_nxt = 1'b1;
            if (sel_r) begin
              sel_nxt     = 1'b0;
              out_clk_nxt = 1'b1;
            end
            if (latch_pend_r) begin
              latch_pend_nxt = 1'b0;
              out_latch_nxt  = 1'b1;
            end
            if (new_gray_r) begin
              new_gray_nxt = 1'b0;
              phase_nxt    = PH_GRAY_SHIFT;
              ch_nxt       = CH_TOP;
              bit_nxt      = GRAY_TOP;
              load_nxt     = 1'b1;
            end
          end
          lpsl_pkg::MODE_TICK: begin
            unique case (phase_r)
              PH_DOT_SHIFT, PH_GRAY_SHIFT: begin
                out_sdata_nxt = shreg_r[GW-1];
                out_clk_nxt   = 1'b1;
                shreg_nxt     = {shreg_r[GW-2:0], 1'b0};
                if (bit_r == '0) begin
                  if (ch_r == '0) begin
                    if (phase_r == PH_DOT_SHIFT) begin
                      phase_nxt = PH_DOT_LATCH;
                    end else begin
                      phase_nxt      = PH_IDLE;
                      latch_pend_nxt = 1'b1;
                    end
                  end else begin
                    ch_nxt    = ch_r - AW'(1);
                    bit_nxt   = (phase_r == PH_DOT_SHIFT) ? DOT_TOP : GRAY_TOP;
                    shreg_nxt = load_word;
                  end
                end else begin
                  bit_nxt = bit_r - BW'(1);
                end
              end
              PH_DOT_LATCH: begin
                out_latch_nxt = 1'b1;
                phase_nxt     = PH_IDLE;
              end
              default: begin
              end
            endcase
          end
          default: begin
            out_acc_nxt = 1'b0;
          end
        endcase
      end
      out_sel_nxt   = sel_nxt;
      out_busy_nxt  = (phase_nxt != PH_IDLE);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      ch_r         <= '0;
      bit_r        <= '0;
      load_r       <= 1'b0;
      new_gray_r   <= 1'b0;
      latch_pend_r <= 1'b0;
      sel_r        <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      ch_r         <= ch_nxt;
      bit_r        <= bit_nxt;
      load_r       <= load_nxt;
      new_gray_r   <= new_gray_nxt;
      latch_pend_r <= latch_pend_nxt;
      sel_r        <= sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    shreg_r     <= shreg_nxt;
    out_sdata_r <= out_sdata_nxt;
    out_clk_r   <= out_clk_nxt;
    out_latch_r <= out_latch_nxt;
    out_blank_r <= out_blank_nxt;
    out_sel_r   <= out_sel_nxt;
    out_busy_r  <= out_busy_nxt;
    out_acc_r   <= out_acc_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_serial_data    = out_sdata_r;
  assign out_clock_pulse    = out_clk_r;
  assign out_latch_pulse    = out_latch_r;
  assign out_blank_pulse    = out_blank_r;
  assign out_program_select = out_sel_r;
  assign out_busy_res       = out_busy_r;
  assign out_accepted       = out_acc_r;

  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    load_r |=> !load_r)
    else $error("store load lasted more than one cycle");

  a_dot_select: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DOT_SHIFT || phase_r == PH_DOT_LATCH) |-> sel_r)
    else $error("program select low during dot correction");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_acc_r) |-> !(out_clk_r || out_latch_r || out_blank_r))
    else $error("pulse on an ignored command");

  a_data_clock: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sdata_r) |-> out_clk_r)
    else $error("serial data without clock pulse");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for led_pwm_driver_serial_loader with a transaction-level pin predictor
// depends on lpsl_pkg and the loader rtl; runs directed, stall and random command tests
module tb;

  localparam int MODE_W     = lpsl_pkg::MODE_W;
  localparam int CHAN_W     = lpsl_pkg::CHAN_W;
  localparam int VALUE_W    = lpsl_pkg::VALUE_W;
  localparam int GRAY_W     = lpsl_pkg::GRAY_W;
  localparam int DOT_W      = lpsl_pkg::DOT_W;
  localparam int N_DRV      = lpsl_pkg::NUM_DRIVERS_DEF;
  localparam int CHANNELS   = lpsl_pkg::CH_PER_DRV * N_DRV;
  localparam int GS_BITS    = CHANNELS * GRAY_W;
  localparam int DC_BITS    = CHANNELS * DOT_W;
  localparam int HOLD_LEN   = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS      = 1750;

  localparam logic [MODE_W-1:0] MODE_UNDEF_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNDEF_LAST  = 3'd7;

  typedef enum logic [1:0] {ST_IDLE, ST_DC_SHIFT, ST_DC_LATCH, ST_GS_SHIFT} loader_st_t;

  typedef struct packed {
    logic serial_data;
    logic clock_pulse;
    logic latch_pulse;
    logic blank_pulse;
    logic program_select;
    logic busy;
    logic accepted;
  } pins_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [CHAN_W-1:0] in_channel = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_serial_data;
  logic out_clock_pulse;
  logic out_latch_pulse;
  logic out_blank_pulse;
  logic out_program_select;
  logic out_busy_res;
  logic out_accepted;

  led_pwm_driver_serial_loader #(.NUM_DRIVERS(N_DRV)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_channel         (in_channel),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_serial_data    (out_serial_data),
    .out_clock_pulse    (out_clock_pulse),
    .out_latch_pulse    (out_latch_pulse),
    .out_blank_pulse    (out_blank_pulse),
    .out_program_select (out_program_select),
    .out_busy_res       (out_busy_res),
    .out_accepted       (out_accepted)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [GRAY_W-1:0] gray_mem [CHANNELS];
  logic [DOT_W-1:0]  dot_mem  [CHANNELS];
  logic       new_gs;
  logic       latch_pend;
  logic       vprg;
  loader_st_t st;
  int         bits_rem;

  pins_t pins_expected[$];
  pins_t mon_exp;
  int    err_cnt = 0;
  int    n_sent = 0;
  int    snd_idle_pct = 0;
  int    rcv_idle_pct = 0;
  bit    hold_req = 1'b0;
  int    hold_cnt = 0;
  int    quiet_cycles = 0;

  function automatic void model_reset();
    for (int i = 0; i < CHANNELS; i++) begin
      gray_mem[i] = '0;
      dot_mem[i]  = lpsl_pkg::DOT_MAX;
    end
    new_gs     = 1'b0;
    latch_pend = 1'b0;
    vprg       = 1'b1;
    st         = ST_IDLE;
    bits_rem   = 0;
  endfunction

  function automatic pins_t pin_model(input logic [MODE_W-1:0] mode,
                                      input logic [CHAN_W-1:0] ch,
                                      input logic [VALUE_W-1:0] val);
    pins_t r;
    int p;
    int ci;
    r = '0;
    ci = int'(ch);
    r.accepted = 1'b1;
    if (mode <= lpsl_pkg::MODE_REFRESH && st != ST_IDLE) begin
      r.accepted = 1'b0;
    end else begin
      case (mode)
        lpsl_pkg::MODE_SET_GRAY: begin
          if (ci < CHANNELS) begin
            gray_mem[ci] = (val > lpsl_pkg::GRAY_MAX) ? lpsl_pkg::GRAY_MAX : val[GRAY_W-1:0];
            new_gs = 1'b1;
          end
        end
        lpsl_pkg::MODE_SET_DOT: begin
          if (ci < CHANNELS) begin
            dot_mem[ci] = (val > lpsl_pkg::DOT_MAX) ? lpsl_pkg::DOT_MAX : val[DOT_W-1:0];
          end
        end
        lpsl_pkg::MODE_PROG_DOT: begin
          vprg     = 1'b1;
          st       = ST_DC_SHIFT;
          bits_rem = DC_BITS;
        end
        lpsl_pkg::MODE_REFRESH: begin
          r.blank_pulse = 1'b1;
          if (vprg) begin
            vprg = 1'b0;
            r.clock_pulse = 1'b1;
          end
          if (latch_pend) begin
            latch_pend = 1'b0;
            r.latch_pulse = 1'b1;
          end
          if (new_gs) begin
            new_gs   = 1'b0;
            st       = ST_GS_SHIFT;
            bits_rem = GS_BITS;
          end
        end
        lpsl_pkg::MODE_TICK: begin
          if (st == ST_DC_SHIFT && bits_rem > 0) begin
            p = bits_rem - 1;
            if (p / DOT_W < CHANNELS) r.serial_data = dot_mem[p / DOT_W][p % DOT_W];
            r.clock_pulse = 1'b1;
            bits_rem = p;
            if (p == 0) st = ST_DC_LATCH;
          end else if (st == ST_DC_LATCH) begin
            r.latch_pulse = 1'b1;
            st = ST_IDLE;
          end else if (st == ST_GS_SHIFT && bits_rem > 0) begin
            p = bits_rem - 1;
            if (p / GRAY_W < CHANNELS) r.serial_data = gray_mem[p / GRAY_W][p % GRAY_W];
            r.clock_pulse = 1'b1;
            bits_rem = p;
            if (p == 0) begin
              st = ST_IDLE;
              latch_pend = 1'b1;
            end
          end else begin
            st = ST_IDLE;
            bits_rem = 0;
          end
        end
        default: r.accepted = 1'b0;
      endcase
    end
    r.program_select = vprg;
    r.busy = (st != ST_IDLE);
    return r;
  endfunction

  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] ch,
                          input logic [VALUE_W-1:0] val);
    pins_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_channel <= ch;
    in_value   <= val;
    do @(posedge clk); while (!in_ready);
    r = pin_model(mode, ch, val);
    pins_expected.push_back(r);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pins_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value(input int max);
    case ($urandom_range(9))
      0:       return '0;
      1:       return VALUE_W'(max);
      2:       return VALUE_W'(max + 1);
      3:       return '1;
      4, 5:    return VALUE_W'($urandom_range(16'hFFFF));
      default: return VALUE_W'($urandom_range(max));
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] rand_channel();
    if ($urandom_range(99) < 85) return CHAN_W'($urandom_range(CHANNELS - 1));
    return CHAN_W'($urandom_range(8'hFF));
  endfunction

  task automatic send_noise(input int top_mode);
    send_cmd(MODE_W'($urandom_range(top_mode)), CHAN_W'($urandom_range(8'hFF)),
             VALUE_W'($urandom_range(16'hFFFF)));
  endtask

  // tick out a running shift, with rejected commands mixed in
  task automatic run_shift();
    while (st != ST_IDLE) begin
      if ($urandom_range(99) < 8) send_noise(MODE_UNDEF_LAST);
      else send_cmd(lpsl_pkg::MODE_TICK, CHAN_W'($urandom_range(8'hFF)),
                    VALUE_W'($urandom_range(16'hFFFF)));
    end
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(2, 1)) begin
        send_cmd(lpsl_pkg::MODE_TICK, rand_channel(), rand_value(lpsl_pkg::GRAY_MAX));
      end
    end
  endtask

  task automatic random_seq();
    int kind;
    if (st != ST_IDLE) run_shift();
    kind = $urandom_range(99);
    if (kind < 40) begin
      repeat ($urandom_range(8, 1)) begin
        if ($urandom_range(99) < 70) begin
          send_cmd(lpsl_pkg::MODE_SET_GRAY, rand_channel(), rand_value(lpsl_pkg::GRAY_MAX));
        end else begin
          send_cmd(lpsl_pkg::MODE_SET_DOT, rand_channel(), rand_value(lpsl_pkg::DOT_MAX));
        end
      end
    end else if (kind < 55) begin
      send_cmd(lpsl_pkg::MODE_PROG_DOT, CHAN_W'($urandom_range(8'hFF)),
               VALUE_W'($urandom_range(16'hFFFF)));
      run_shift();
    end else if (kind < 85) begin
      send_cmd(lpsl_pkg::MODE_REFRESH, CHAN_W'($urandom_range(8'hFF)),
               VALUE_W'($urandom_range(16'hFFFF)));
      run_shift();
    end else begin
      repeat ($urandom_range(4, 1)) send_noise(MODE_UNDEF_LAST);
      run_shift();
    end
  endtask

  task automatic test_directed();
    send_cmd(lpsl_pkg::MODE_TICK, 8'h00, 16'h0000);
    send_cmd(MODE_UNDEF_FIRST, 8'hFF, 16'hFFFF);
    send_cmd(MODE_UNDEF_LAST, 8'h00, 16'h0000);
    send_cmd(lpsl_pkg::MODE_SET_GRAY, 8'd0, 16'd0);
    send_cmd(lpsl_pkg::MODE_SET_GRAY, CHAN_W'(CHANNELS - 1), VALUE_W'(lpsl_pkg::GRAY_MAX));
    send_cmd(lpsl_pkg::MODE_SET_GRAY, 8'd1, VALUE_W'(lpsl_pkg::GRAY_MAX + 1));
    send_cmd(lpsl_pkg::MODE_SET_GRAY, 8'd2, 16'hFFFF);
    send_cmd(lpsl_pkg::MODE_SET_GRAY, CHAN_W'(CHANNELS), 16'd1234);
    send_cmd(lpsl_pkg::MODE_SET_GRAY, 8'hFF, 16'h5555);
    send_cmd(lpsl_pkg::MODE_SET_DOT, 8'd0, 16'd0);
    send_cmd(lpsl_pkg::MODE_SET_DOT, CHAN_W'(CHANNELS - 1), VALUE_W'(lpsl_pkg::DOT_MAX));
    send_cmd(lpsl_pkg::MODE_SET_DOT, 8'd3, VALUE_W'(lpsl_pkg::DOT_MAX + 1));
    send_cmd(lpsl_pkg::MODE_SET_DOT, 8'd4, 16'hFFFF);
    send_cmd(lpsl_pkg::MODE_SET_DOT, 8'hFF, 16'h002A);
    // first refresh: program select high and new grayscale pending
    send_cmd(lpsl_pkg::MODE_REFRESH, 8'h00, 16'h0000);
    send_cmd(lpsl_pkg::MODE_SET_GRAY, 8'd5, 16'd7);
    send_cmd(lpsl_pkg::MODE_SET_DOT, 8'd5, 16'd7);
    send_cmd(lpsl_pkg::MODE_PROG_DOT, 8'd0, 16'd0);
    send_cmd(lpsl_pkg::MODE_REFRESH, 8'd0, 16'd0);
    send_cmd(lpsl_pkg::MODE_TICK, 8'hAA, 16'hAAAA);
    run_shift();
    // latch pending from the shift, then program dot correction keeps it
    send_cmd(lpsl_pkg::MODE_PROG_DOT, 8'h55, 16'h5555);
    run_shift();
    send_cmd(lpsl_pkg::MODE_REFRESH, 8'd0, 16'd0);
    send_cmd(lpsl_pkg::MODE_REFRESH, 8'd0, 16'd0);
  endtask

  task automatic test_hold_off();
    rcv_idle_pct = 0;
    snd_idle_pct = 0;
    hold_req = 1'b1;
    repeat (60) begin
      if ($urandom_range(1)) begin
        send_cmd(lpsl_pkg::MODE_TICK, rand_channel(), rand_value(lpsl_pkg::GRAY_MAX));
      end else begin
        send_cmd(lpsl_pkg::MODE_SET_GRAY, rand_channel(), rand_value(lpsl_pkg::GRAY_MAX));
      end
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (3) random_seq();
    wait_drained();
    repeat (3) random_seq();
  endtask

  task automatic test_random(input int goal);
    while (n_sent < goal) random_seq();
  endtask

  task automatic chk_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pins_expected.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        mon_exp = pins_expected.pop_front();
        chk_field("serial_data", mon_exp.serial_data, out_serial_data);
        chk_field("clock_pulse", mon_exp.clock_pulse, out_clock_pulse);
        chk_field("latch_pulse", mon_exp.latch_pulse, out_latch_pulse);
        chk_field("blank_pulse", mon_exp.blank_pulse, out_blank_pulse);
        chk_field("program_select", mon_exp.program_select, out_program_select);
        chk_field("busy_res", mon_exp.busy, out_busy_res);
        chk_field("accepted", mon_exp.accepted, out_accepted);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle_pct = 25;
    rcv_idle_pct = 68;
    test_directed();
    test_random(ITEMS / 3);
    snd_idle_pct = 68;
    rcv_idle_pct = 25;
    test_random(2 * ITEMS / 3);
    test_hold_off();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_drain_pause();
    test_random(ITEMS);
    wait_drained();
    repeat (20) @(posedge clk);
    if (pins_expected.size() != 0) begin
      $error("%0d result transactions never arrived", pins_expected.size());
      err_cnt++;
    end
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
